// ===== hw/rtl/tns_pkg.sv =====
// shared types, codes and constants of the tone note sequencer
package tns_pkg;

    // request kinds carried on the input tuser
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_TONE   = 3'd1;
    localparam logic [2:0] KIND_START  = 3'd2;
    localparam logic [2:0] KIND_APPEND = 3'd3;
    localparam logic [2:0] KIND_NOISE  = 3'd4;

    // output channel codes
    localparam logic CHAN_SQUARE = 1'b0;
    localparam logic CHAN_NOISE  = 1'b1;

    // default depth of the note queue
    localparam int QUEUE_DEPTH_DEF = 4;

    // input tdata layout, lowest bit first
    localparam int IN_HZ_LSB    = 0;
    localparam int IN_VOL_LSB   = 16;
    localparam int IN_ENV_LSB   = 20;
    localparam int IN_DUTY_LSB  = 23;
    localparam int IN_WAIT_LSB  = 25;
    localparam int IN_NOISE_LSB = 33;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 32;

    // rate divider: 131072 / hz, one quotient bit per cycle
    localparam int          DIV_STEPS    = 18;
    localparam int          DIV_CNT_W    = 5;
    localparam logic [17:0] DIVIDEND     = 18'h20000;
    localparam logic [11:0] RATE_BASE    = 12'd2048;
    localparam logic [15:0] TRIGGER_BIT  = 16'h8000;
    localparam logic [15:0] NOISE_MASK   = 16'h40FF;
    localparam logic [1:0]  QUEUED_DUTY  = 2'd2;

    // one queued note
    typedef struct packed {
        logic [7:0]  wait_ticks;
        logic [15:0] hz;
        logic [3:0]  vol;
        logic [2:0]  env;
    } note_t;

    // queue operations for one accepted request or a register write
    typedef struct packed {
        logic tick;
        logic append;
        logic restart;
        logic flush;
    } queue_op_t;

endpackage

// ===== hw/rtl/tns_divider.sv =====
// bit-serial restoring divider giving 131072 / divisor
module tns_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [17:0] quotient
);
    import tns_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [16:0]          rem_reg, rem_next;
    logic [17:0]          dq_reg, dq_next;
    logic [15:0]          dvs_reg, dvs_next;
    logic [16:0]          rem_shift;
    logic                 fits;

    // one trial subtraction per cycle
    assign rem_shift = {rem_reg[15:0], dq_reg[17]};
    assign fits      = (rem_shift >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            rem_next  = '0;
            dq_next   = DIVIDEND;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
            dq_next  = {dq_reg[16:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ===== hw/rtl/tns_queue.sv =====
// note queue with fill count, play position and tick delay
module tns_queue #(
    parameter int DEPTH = tns_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tns_pkg::queue_op_t op,
    input  tns_pkg::note_t    note_in,
    output logic              play,
    output tns_pkg::note_t    note_out
);
    import tns_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    note_t            queue_mem [DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [7:0]       delay_reg, delay_next;
    logic [CNT_W-1:0] pos_inc;
    logic             has_note;
    logic             room;

    assign has_note = (pos_reg < count_reg);
    assign room     = (count_reg < DEPTH_C);
    assign pos_inc  = pos_reg + 1'b1;
    assign note_out = queue_mem[pos_reg[IDX_W-1:0]];
    assign play     = op.tick && has_note && (delay_reg == '0);

    // queue bookkeeping
    always_comb begin
        count_next = count_reg;
        pos_next   = pos_reg;
        delay_next = delay_reg;
        if (op.tick && has_note) begin
            if (delay_reg != '0) begin
                delay_next = delay_reg - 1'b1;
            end else begin
                delay_next = note_out.wait_ticks;
                if (pos_inc >= count_reg) begin
                    count_next = '0;
                    pos_next   = '0;
                end else begin
                    pos_next = pos_inc;
                end
            end
        end
        if (op.append && room) begin
            count_next = count_reg + 1'b1;
        end
        if (op.restart) begin
            count_next = '0;
            pos_next   = '0;
            delay_next = '0;
        end
        if (op.flush) begin
            count_next = '0;
            pos_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pos_reg   <= '0;
            delay_reg <= '0;
        end else begin
            count_reg <= count_next;
            pos_reg   <= pos_next;
            delay_reg <= delay_next;
        end
    end

    // note storage, written at the fill count
    always_ff @(posedge aclk) begin
        if (op.append && room) begin
            queue_mem[count_reg[IDX_W-1:0]] <= note_in;
        end
    end

endmodule

// ===== hw/rtl/tone_note_sequencer_core.sv =====
// tone note sequencer top level: request decode, sequencing and output register
//
// Takes one request at a time on the s_axis side; the kind travels on tuser.
// A request that fires no note (append, tick still counting down, disabled
// output, unused kinds) leaves the sequencer idle, so tready stays high. A
// noise request goes straight to the push state. A square note (tone, start,
// or a tick that plays a queued note) passes in order through launching the
// divider, the bit-serial divider that forms 131072 / Hz one quotient bit a
// cycle, its done flag and the load of the output register before the next
// ready. A finished result sits in the m_axis output register, so the next
// request is taken while it waits; a following note then holds in the push
// state until the output register is free.
// The enable register (reset 1) is written via cfg_valid/cfg_data; the user
// writes it only while the block is idle (not enforced); 0 empties the queue.
module tone_note_sequencer_core #(
    parameter int QUEUE_DEPTH = tns_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // hz[15:0], volume[19:16], envelope_step[22:20], duty[24:23],
    // wait_ticks[32:25], noise_divider[48:33], zero fill above
    input  logic [tns_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]                      s_axis_tuser,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // control_word[15:0], frequency_word[31:16]
    output logic [tns_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // channel[0]
    output logic                            m_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data
);
    import tns_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic        enabled_reg, enabled_next;
    logic        chan_reg, chan_next;
    logic [15:0] ctrl_reg, ctrl_next;
    logic [15:0] freq_reg, freq_next;
    logic        m_valid_reg, m_valid_next;
    logic        m_chan_reg, m_chan_next;
    logic [15:0] m_ctrl_reg, m_ctrl_next;
    logic [15:0] m_freq_reg, m_freq_next;

    logic [2:0]  kind;
    logic [15:0] in_hz;
    logic [3:0]  in_vol;
    logic [2:0]  in_env;
    logic [1:0]  in_duty;
    logic [7:0]  in_wait;
    logic [15:0] in_noise;
    logic        accept;
    logic        cfg_write;
    logic        emit_sq;
    logic        emit_nz;
    queue_op_t   q_op;
    note_t       q_in;
    note_t       q_note;
    logic        q_play;
    logic        div_start;
    logic [15:0] sq_hz;
    logic [15:0] div_hz;
    logic        div_done;
    logic [17:0] div_quot;
    logic [11:0] rate_diff;
    logic [10:0] rate;
    logic        out_free;

    // request field unpacking
    assign kind     = s_axis_tuser;
    assign in_hz    = s_axis_tdata[IN_HZ_LSB +: 16];
    assign in_vol   = s_axis_tdata[IN_VOL_LSB +: 4];
    assign in_env   = s_axis_tdata[IN_ENV_LSB +: 3];
    assign in_duty  = s_axis_tdata[IN_DUTY_LSB +: 2];
    assign in_wait  = s_axis_tdata[IN_WAIT_LSB +: 8];
    assign in_noise = s_axis_tdata[IN_NOISE_LSB +: 16];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cfg_write     = cfg_valid && cfg_ready;

    // queue operations
    assign q_op.tick    = accept && (kind == KIND_TICK);
    assign q_op.append  = accept && (kind == KIND_APPEND);
    assign q_op.restart = accept && (kind == KIND_START) && enabled_reg;
    assign q_op.flush   = cfg_write && !cfg_data;
    assign q_in.wait_ticks = in_wait;
    assign q_in.hz         = in_hz;
    assign q_in.vol        = in_vol;
    assign q_in.env        = in_env;

    tns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (q_op),
        .note_in  (q_in),
        .play     (q_play),
        .note_out (q_note)
    );

    // which requests sound a note
    assign emit_sq = accept && enabled_reg &&
                     ((kind == KIND_TONE) || (kind == KIND_START) ||
                      ((kind == KIND_TICK) && q_play));
    assign emit_nz = accept && enabled_reg && (kind == KIND_NOISE);

    // divider launch, zero hertz counts as one
    assign sq_hz     = (kind == KIND_TICK) ? q_note.hz : in_hz;
    assign div_hz    = (sq_hz == '0) ? 16'd1 : sq_hz;
    assign div_start = emit_sq;

    tns_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (div_hz),
        .done     (div_done),
        .quotient (div_quot)
    );

    // square rate from the quotient, zero once it reaches 2048
    assign rate_diff = RATE_BASE - {1'b0, div_quot[10:0]};
    assign rate      = (div_quot[17:11] != '0) ? 11'd0 : rate_diff[10:0];

    assign out_free = !m_valid_reg || m_axis_tready;

    // sequencer and pending result
    always_comb begin
        state_next   = state_reg;
        enabled_next = cfg_write ? cfg_data : enabled_reg;
        chan_next    = chan_reg;
        ctrl_next    = ctrl_reg;
        freq_next    = freq_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_chan_next  = m_chan_reg;
        m_ctrl_next  = m_ctrl_reg;
        m_freq_next  = m_freq_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (emit_sq) begin
                    chan_next = CHAN_SQUARE;
                    if (kind == KIND_TICK) begin
                        ctrl_next = {q_note.vol, 1'b0, q_note.env, QUEUED_DUTY, 6'd0};
                    end else begin
                        ctrl_next = {in_vol, 1'b0, in_env, in_duty, 6'd0};
                    end
                    state_next = ST_DIV;
                end else if (emit_nz) begin
                    chan_next  = CHAN_NOISE;
                    ctrl_next  = {in_vol, 1'b0, in_env, 8'd0};
                    freq_next  = TRIGGER_BIT | (in_noise & NOISE_MASK);
                    state_next = ST_PUSH;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    freq_next  = TRIGGER_BIT | {5'd0, rate};
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_chan_next  = chan_reg;
                    m_ctrl_next  = ctrl_reg;
                    m_freq_next  = freq_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            enabled_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            enabled_reg <= enabled_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        chan_reg   <= chan_next;
        ctrl_reg   <= ctrl_next;
        freq_reg   <= freq_next;
        m_chan_reg <= m_chan_next;
        m_ctrl_reg <= m_ctrl_next;
        m_freq_reg <= m_freq_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_chan_reg;
    assign m_axis_tdata  = {m_freq_reg, m_ctrl_reg};

`ifndef SYNTHESIS
    // divider only finishes while the sequencer waits on it
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");

    // a sounding request always leaves idle
    a_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_sq || emit_nz) |=> (state_reg != ST_IDLE))
        else $error("sounding request did not start work");

    // a pending result waits while the output register is blocked
    a_push_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_PUSH) && m_valid_reg && !m_axis_tready)
        |=> (state_reg == ST_PUSH))
        else $error("pending result dropped while output stalled");

    // the divider is launched only with a non-zero divisor
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (div_hz != '0))
        else $error("divider started with zero divisor");
`endif

endmodule
